/* hdl/pse_pkg.sv */
package pse_pkg;

   localparam int unsigned LOOK_DEPTH   = 4;
   localparam int unsigned HDR_FIXED    = 3;
   localparam int unsigned PES_OVERHEAD = 6;

   localparam logic [23:0] START_PREFIX = 24'h000001;
   localparam logic [7:0]  ID_VIDEO     = 8'hE0;
   localparam logic [7:0]  ID_PACK      = 8'hBA;
   localparam logic [7:0]  BYTE_ZERO    = 8'h00;
   localparam logic [7:0]  BYTE_ONE     = 8'h01;

   // results of one request, drained one per cycle while rsp_chan is ready
   typedef struct packed {
      logic [2:0]                       count;
      logic [LOOK_DEPTH-1:0][7:0]       es_bytes;
      logic [LOOK_DEPTH-1:0]            starts;
   } bundle_type;

   function automatic bundle_type push(bundle_type b, logic [7:0] d, logic s);
      bundle_type r;
      r = b;
      if (r.count < 3'(LOOK_DEPTH)) begin
         r.es_bytes[r.count[1:0]] = d;
         r.starts[r.count[1:0]]   = s;
         r.count                  = r.count + 3'd1;
      end
      return r;
   endfunction

endpackage

/* hdl/pse_if.sv */
interface pse_req_if #(parameter int CHUNK_SIZE_BITS = 20) ();
   logic                       valid;
   logic                       ready;
   logic [7:0]                 data_byte;
   logic                       chunk_first;
   logic                       chunk_last;
   logic [CHUNK_SIZE_BITS-1:0] chunk_size;

   modport source (output valid, data_byte, chunk_first, chunk_last, chunk_size,
                   input ready);
   modport sink (input valid, data_byte, chunk_first, chunk_last, chunk_size,
                 output ready);
endinterface

interface pse_rsp_if ();
   logic       valid;
   logic       ready;
   logic [7:0] es_byte;
   logic       frame_start;
   logic       run_last;

   modport source (output valid, es_byte, frame_start, run_last, input ready);
   modport sink (input valid, es_byte, frame_start, run_last, output ready);
endinterface

/* hdl/ps_to_h264_es_extractor_top.sv */
// Results of a request are registered and appear on rsp_chan the cycle after it is accepted.
// A new request is taken every cycle while each yields at most one result and rsp_chan is ready;
// a request yielding n results (up to 4) holds the result buffer until all n are drained.
// Reset: synchronous, clears parser state and the result buffer.
module ps_to_h264_es_extractor_top #(
   parameter int CHUNK_SIZE_BITS = 20
) (
   input logic        clock,
   input logic        reset,
   pse_req_if.sink    req_chan,
   pse_rsp_if.source  rsp_chan
);
   import pse_pkg::*;

   bundle_type bundle_ff, bundle_in, step_bundle;
   logic [1:0] idx_ff, idx_in;
   logic       accept, entry_last, rsp_take;

   pse_parser #(
      .CHUNK_SIZE_BITS (CHUNK_SIZE_BITS)
   ) u_parser (
      .clock       (clock),
      .reset       (reset),
      .step_en     (accept),
      .data_byte   (req_chan.data_byte),
      .chunk_first (req_chan.chunk_first),
      .chunk_last  (req_chan.chunk_last),
      .chunk_size  (req_chan.chunk_size),
      .bundle      (step_bundle)
   );

   assign entry_last           = ({1'b0, idx_ff} + 3'd1) == bundle_ff.count;
   assign rsp_chan.valid       = bundle_ff.count != 3'd0;
   assign rsp_chan.es_byte     = bundle_ff.es_bytes[idx_ff];
   assign rsp_chan.frame_start = bundle_ff.starts[idx_ff];
   assign rsp_chan.run_last    = entry_last;
   assign rsp_take             = rsp_chan.valid && rsp_chan.ready;
   assign req_chan.ready       = (bundle_ff.count == 3'd0) || (rsp_take && entry_last);
   assign accept               = req_chan.valid && req_chan.ready;

   always_comb begin
      bundle_in = bundle_ff;
      idx_in    = idx_ff;
      if (accept) begin
         bundle_in = step_bundle;
         idx_in    = '0;
      end else if (rsp_take) begin
         if (entry_last) begin
            bundle_in.count = 3'd0;
            idx_in          = '0;
         end else begin
            idx_in = idx_ff + 2'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bundle_ff.count <= 3'd0;
         idx_ff          <= '0;
      end else begin
         bundle_ff.count <= bundle_in.count;
         idx_ff          <= idx_in;
      end
      bundle_ff.es_bytes <= bundle_in.es_bytes;
      bundle_ff.starts   <= bundle_in.starts;
   end

endmodule

/* hdl/pse_parser.sv */
module pse_parser #(
   parameter int CHUNK_SIZE_BITS = 20
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       step_en,
   input  logic [7:0]                 data_byte,
   input  logic                       chunk_first,
   input  logic                       chunk_last,
   input  logic [CHUNK_SIZE_BITS-1:0] chunk_size,
   output pse_pkg::bundle_type        bundle
);
   import pse_pkg::*;

   typedef enum logic [2:0] {
      PH_SCAN, PH_LEN_HI, PH_LEN_LO, PH_HDR, PH_SKIP, PH_ES
   } phase_type;

   typedef enum logic [1:0] {
      MODE_IGNORE, MODE_DECIDE, MODE_SINGLE, MODE_SCAN
   } mode_type;

   logic [31:0]                win_ff, win_in;
   logic [CHUNK_SIZE_BITS-1:0] pos_ff, pos_in, pos_cur;
   logic [CHUNK_SIZE_BITS:0]   pos_inc;
   mode_type                   mode_ff, mode_in;
   phase_type                  phase_ff, phase_in;
   logic [15:0]                left_ff, left_in;
   logic [7:0]                 skip_ff, skip_in;
   logic [2:0]                 pidx_ff, pidx_in;
   logic [LOOK_DEPTH-1:0][7:0] look_ff, look_in;
   logic                       open_ff, open_in;
   logic [16:0]                need;
   logic                       start;
   bundle_type                 bnd;

   function automatic bundle_type flush_held(bundle_type b, logic [2:0] n, logic open,
                                             logic [LOOK_DEPTH-1:0][7:0] look);
      bundle_type r;
      r = b;
      for (int i = 0; i < LOOK_DEPTH - 1; i++) begin
         if (3'(i) < n && open) begin
            r = push(r, look[i], 1'b0);
         end
      end
      return r;
   endfunction

   always_comb begin
      bnd      = '0;
      win_in   = win_ff;
      mode_in  = mode_ff;
      phase_in = phase_ff;
      left_in  = left_ff;
      skip_in  = skip_ff;
      pidx_in  = pidx_ff;
      look_in  = look_ff;
      open_in  = open_ff;
      pos_cur  = pos_ff;
      need     = '0;
      start    = 1'b0;

      if (chunk_first) begin
         if (phase_in == PH_ES && pidx_in < 3'(LOOK_DEPTH)) begin
            bnd = flush_held(bnd, pidx_in, open_in, look_in);
         end
         phase_in = PH_SCAN;
         mode_in  = MODE_DECIDE;
         win_in   = '0;
         left_in  = '0;
         skip_in  = '0;
         pidx_in  = '0;
         pos_cur  = '0;
      end

      pos_inc = {1'b0, pos_cur} + (CHUNK_SIZE_BITS+1)'(1);
      win_in  = {win_in[23:0], data_byte};

      if (mode_in != MODE_IGNORE) begin
         unique case (phase_in)
            PH_SCAN: begin
               if (mode_in == MODE_DECIDE) begin
                  if (pos_cur == CHUNK_SIZE_BITS'(HDR_FIXED)) begin
                     if (win_in == {START_PREFIX, ID_VIDEO}) begin
                        mode_in  = MODE_SINGLE;
                        phase_in = PH_LEN_HI;
                     end else if (win_in == {START_PREFIX, ID_PACK}) begin
                        mode_in = MODE_SCAN;
                     end else begin
                        mode_in = MODE_IGNORE;
                     end
                  end
               end else if (mode_in == MODE_SCAN && win_in == {START_PREFIX, ID_VIDEO} &&
                            pos_inc < {1'b0, chunk_size}) begin
                  phase_in = PH_LEN_HI;
               end
            end
            PH_LEN_HI: begin
               left_in  = {data_byte, 8'h00};
               phase_in = PH_LEN_LO;
            end
            PH_LEN_LO: begin
               left_in = {left_in[15:8], data_byte};
               pidx_in = '0;
               need    = {1'b0, left_in} + 17'(PES_OVERHEAD);
               if (mode_in == MODE_SINGLE && 33'(chunk_size) < 33'(need)) begin
                  mode_in  = MODE_IGNORE;
                  phase_in = PH_SCAN;
               end else if (left_in == 16'd0) begin
                  phase_in = PH_SCAN;
                  win_in   = '0;
               end else begin
                  phase_in = PH_HDR;
               end
            end
            PH_HDR, PH_SKIP, PH_ES: begin
               if (phase_in == PH_HDR) begin
                  if (pidx_in >= 3'(HDR_FIXED - 1)) begin
                     skip_in  = data_byte;
                     pidx_in  = '0;
                     phase_in = (data_byte != 8'd0) ? PH_SKIP : PH_ES;
                  end else begin
                     pidx_in = pidx_in + 3'd1;
                  end
               end else if (phase_in == PH_SKIP) begin
                  skip_in = skip_in - 8'd1;
                  if (skip_in == 8'd0) begin
                     pidx_in  = '0;
                     phase_in = PH_ES;
                  end
               end else begin
                  if (pidx_in < 3'(LOOK_DEPTH)) begin
                     look_in[pidx_in[1:0]] = data_byte;
                     pidx_in = pidx_in + 3'd1;
                     if (pidx_in == 3'(LOOK_DEPTH)) begin
                        start = look_in[0] == BYTE_ZERO && look_in[1] == BYTE_ZERO &&
                                look_in[2] == BYTE_ZERO && look_in[3] == BYTE_ONE;
                        if (start) begin
                           open_in = 1'b1;
                        end
                        if (open_in) begin
                           for (int i = 0; i < LOOK_DEPTH; i++) begin
                              bnd = push(bnd, look_in[i], start && i == 0);
                           end
                        end
                     end
                  end else if (open_in) begin
                     bnd = push(bnd, data_byte, 1'b0);
                  end
               end
               left_in = left_in - 16'd1;
               if (left_in == 16'd0) begin
                  if (phase_in == PH_ES && pidx_in < 3'(LOOK_DEPTH)) begin
                     bnd     = flush_held(bnd, pidx_in, open_in, look_in);
                     pidx_in = 3'(LOOK_DEPTH);
                  end
                  phase_in = PH_SCAN;
                  win_in   = '0;
               end
            end
            default: begin
               phase_in = PH_SCAN;
            end
         endcase
      end

      if (chunk_last) begin
         if (phase_in == PH_ES && pidx_in < 3'(LOOK_DEPTH)) begin
            bnd     = flush_held(bnd, pidx_in, open_in, look_in);
            pidx_in = 3'(LOOK_DEPTH);
         end
         phase_in = PH_SCAN;
         mode_in  = MODE_IGNORE;
      end

      pos_in = pos_inc[CHUNK_SIZE_BITS-1:0];
   end

   assign bundle = bnd;

   always_ff @(posedge clock) begin
      if (reset) begin
         win_ff   <= '0;
         pos_ff   <= '0;
         mode_ff  <= MODE_IGNORE;
         phase_ff <= PH_SCAN;
         left_ff  <= '0;
         skip_ff  <= '0;
         pidx_ff  <= '0;
         look_ff  <= '0;
         open_ff  <= 1'b0;
      end else if (step_en) begin
         win_ff   <= win_in;
         pos_ff   <= pos_in;
         mode_ff  <= mode_in;
         phase_ff <= phase_in;
         left_ff  <= left_in;
         skip_ff  <= skip_in;
         pidx_ff  <= pidx_in;
         look_ff  <= look_in;
         open_ff  <= open_in;
      end
   end

endmodule

/* dv/ps_to_h264_es_extractor_top_tb.sv */
module ps_to_h264_es_extractor_top_tb;
   import pse_pkg::*;

   localparam int SIZE_BITS = 20;
   localparam logic [31:0] VIDEO_CODE = {START_PREFIX, ID_VIDEO};
   localparam logic [31:0] PACK_CODE  = {START_PREFIX, ID_PACK};

   typedef enum logic [1:0] {CH_IGNORE, CH_DECIDE, CH_ONE_PES, CH_SCAN} chunk_kind_type;
   typedef enum logic [3:0] {ST_HUNT, ST_LEN_HI, ST_LEN_LO, ST_HDR, ST_SKIP, ST_ES} parse_st_type;

   typedef struct packed {
      logic [7:0]           data_byte;
      logic                 chunk_first;
      logic                 chunk_last;
      logic [SIZE_BITS-1:0] chunk_size;
   } ps_byte_type;

   typedef struct packed {
      logic [7:0] es_byte;
      logic       frame_start;
      logic       run_last;
   } es_result_type;

   logic clock = 1'b0;
   logic reset;

   pse_req_if #(.CHUNK_SIZE_BITS(SIZE_BITS)) req_chan ();
   pse_rsp_if rsp_chan ();

   ps_to_h264_es_extractor_top #(.CHUNK_SIZE_BITS(SIZE_BITS)) i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // extractor state as seen from outside
   logic [31:0]          window         = '0;
   logic [SIZE_BITS-1:0] byte_pos       = '0;
   chunk_kind_type       chunk_kind     = CH_IGNORE;
   parse_st_type         parse_st       = ST_HUNT;
   logic [15:0]          pes_remaining  = '0;
   logic [7:0]           skip_remaining = '0;
   int unsigned          hold_count     = 0;
   logic [7:0]           held_bytes [LOOK_DEPTH];
   bit                   frame_seen     = 1'b0;

   es_result_type step_out [$];
   es_result_type expected_es [$];
   logic [7:0] chunk_bytes [$];

   int src_idle_pct = 25;
   int rsp_idle_pct = 56;
   int fail_count   = 0;
   int items_sent   = 0;
   int stream_items = 0;
   int results_seen = 0;
   int frames_seen  = 0;
   int last_pes_len = 0;

   function automatic logic [7:0] rnd_byte();
      return 8'($urandom_range(0, 255));
   endfunction

   function automatic void emit_es(logic [7:0] b, logic fs);
      if (step_out.size() < LOOK_DEPTH)
         step_out.push_back('{b, fs, 1'b0});
   endfunction

   // release held bytes that can no longer form a frame start
   function automatic void flush_short_es();
      int i;
      if (parse_st == ST_ES && hold_count < LOOK_DEPTH) begin
         if (frame_seen)
            for (i = 0; i < hold_count; i++)
               emit_es(held_bytes[i], 1'b0);
         hold_count = LOOK_DEPTH;
      end
   endfunction

   function automatic void close_pes();
      flush_short_es();
      parse_st = ST_HUNT;
      window   = '0;
   endfunction

   function automatic void predict_es(input ps_byte_type r);
      logic [SIZE_BITS-1:0] pos;
      bit                   start;
      int                   i;
      step_out.delete();
      if (r.chunk_first) begin
         if (parse_st != ST_HUNT)
            flush_short_es();
         parse_st       = ST_HUNT;
         chunk_kind     = CH_DECIDE;
         window         = '0;
         pes_remaining  = '0;
         skip_remaining = '0;
         hold_count     = 0;
         pos            = '0;
      end else begin
         pos = byte_pos;
      end
      window = {window[23:0], r.data_byte};
      if (chunk_kind != CH_IGNORE) begin
         case (parse_st)
            ST_HUNT: begin
               if (chunk_kind == CH_DECIDE) begin
                  if (pos == SIZE_BITS'(3)) begin
                     if (window == VIDEO_CODE) begin
                        chunk_kind = CH_ONE_PES;
                        parse_st   = ST_LEN_HI;
                     end else if (window == PACK_CODE) begin
                        chunk_kind = CH_SCAN;
                     end else begin
                        chunk_kind = CH_IGNORE;
                     end
                  end
               end else if (chunk_kind == CH_SCAN && window == VIDEO_CODE &&
                            64'(pos) + 64'd1 < 64'(r.chunk_size)) begin
                  parse_st = ST_LEN_HI;
               end
            end
            ST_LEN_HI: begin
               pes_remaining = {r.data_byte, 8'h00};
               parse_st      = ST_LEN_LO;
            end
            ST_LEN_LO: begin
               pes_remaining = {pes_remaining[15:8], r.data_byte};
               hold_count    = 0;
               if (chunk_kind == CH_ONE_PES &&
                   64'(r.chunk_size) < 64'(pes_remaining) + 64'(PES_OVERHEAD)) begin
                  chunk_kind = CH_IGNORE;
                  parse_st   = ST_HUNT;
               end else if (pes_remaining == 16'd0) begin
                  close_pes();
               end else begin
                  parse_st = ST_HDR;
               end
            end
            default: begin
               if (parse_st == ST_HDR) begin
                  if (hold_count >= HDR_FIXED - 1) begin
                     skip_remaining = r.data_byte;
                     hold_count     = 0;
                     parse_st       = (skip_remaining != 8'd0) ? ST_SKIP : ST_ES;
                  end else begin
                     hold_count++;
                  end
               end else if (parse_st == ST_SKIP) begin
                  skip_remaining = skip_remaining - 8'd1;
                  if (skip_remaining == 8'd0) begin
                     hold_count = 0;
                     parse_st   = ST_ES;
                  end
               end else begin
                  if (hold_count < LOOK_DEPTH) begin
                     held_bytes[hold_count] = r.data_byte;
                     hold_count++;
                     if (hold_count == LOOK_DEPTH) begin
                        start = held_bytes[0] == BYTE_ZERO && held_bytes[1] == BYTE_ZERO &&
                                held_bytes[2] == BYTE_ZERO && held_bytes[3] == BYTE_ONE;
                        if (start)
                           frame_seen = 1'b1;
                        if (frame_seen)
                           for (i = 0; i < LOOK_DEPTH; i++)
                              emit_es(held_bytes[i], start && i == 0);
                     end
                  end else if (frame_seen) begin
                     emit_es(r.data_byte, 1'b0);
                  end
               end
               pes_remaining = pes_remaining - 16'd1;
               if (pes_remaining == 16'd0)
                  close_pes();
            end
         endcase
      end
      if (r.chunk_last) begin
         if (parse_st != ST_HUNT)
            flush_short_es();
         parse_st   = ST_HUNT;
         chunk_kind = CH_IGNORE;
      end
      byte_pos = pos + SIZE_BITS'(1);
      foreach (step_out[k]) begin
         if (k == step_out.size() - 1)
            step_out[k].run_last = 1'b1;
         expected_es.push_back(step_out[k]);
      end
   endfunction

   task automatic send_req(input logic [7:0] d, input bit first, input bit last,
                           input logic [SIZE_BITS-1:0] size);
      ps_byte_type r;
      r = '{d, first, last, size};
      while (src_idle_pct != 0 && $urandom_range(0, 99) < src_idle_pct) begin
         req_chan.valid <= 1'b0;
         @(negedge clock);
      end
      req_chan.valid       <= 1'b1;
      req_chan.data_byte   <= r.data_byte;
      req_chan.chunk_first <= r.chunk_first;
      req_chan.chunk_last  <= r.chunk_last;
      req_chan.chunk_size  <= r.chunk_size;
      do
         @(posedge clock);
      while (req_chan.ready !== 1'b1);
      predict_es(r);
      items_sent++;
      @(negedge clock);
   endtask

   task automatic send_chunk(input logic [SIZE_BITS-1:0] size, input bit close,
                             input bit counted);
      int i;
      for (i = 0; i < chunk_bytes.size(); i++) begin
         send_req(chunk_bytes[i], i == 0, close && i == chunk_bytes.size() - 1, size);
         if (counted)
            stream_items++;
      end
   endtask

   // append one video PES with random layout to the chunk being built
   task automatic add_pes();
      int         kind;
      int         hdr_n;
      int         es_n;
      int         len;
      logic [7:0] body [$];
      kind = $urandom_range(0, 9);
      body.delete();
      if (kind == 0) begin
         len = 0;
      end else if (kind == 1) begin
         repeat ($urandom_range(1, 3)) body.push_back(rnd_byte());
         len = body.size();
      end else if (kind == 2) begin
         repeat ($urandom_range(0, 6)) body.push_back(rnd_byte());
         len = $urandom_range(0, 65535);
      end else begin
         hdr_n = ($urandom_range(0, 7) == 0) ? $urandom_range(3, 12) : $urandom_range(0, 2);
         es_n  = $urandom_range(0, 10);
         body.push_back(rnd_byte());
         body.push_back(rnd_byte());
         body.push_back(8'(hdr_n));
         repeat (hdr_n) body.push_back(rnd_byte());
         if (es_n >= LOOK_DEPTH && $urandom_range(0, 99) < 65) begin
            body.push_back(BYTE_ZERO);
            body.push_back(BYTE_ZERO);
            body.push_back(BYTE_ZERO);
            body.push_back(($urandom_range(0, 9) == 0) ? rnd_byte() : BYTE_ONE);
            es_n -= LOOK_DEPTH;
         end
         repeat (es_n) body.push_back(($urandom_range(0, 3) == 0) ? BYTE_ZERO : rnd_byte());
         len = body.size();
         // cut the PES short of its stated length
         if (body.size() > 0 && $urandom_range(0, 11) == 0)
            repeat ($urandom_range(1, body.size())) void'(body.pop_back());
      end
      last_pes_len = len;
      chunk_bytes.push_back(BYTE_ZERO);
      chunk_bytes.push_back(BYTE_ZERO);
      chunk_bytes.push_back(BYTE_ONE);
      chunk_bytes.push_back(ID_VIDEO);
      chunk_bytes.push_back(8'(len >> 8));
      chunk_bytes.push_back(8'(len));
      foreach (body[j]) chunk_bytes.push_back(body[j]);
   endtask

   task automatic test_pack_scan_drop();
      chunk_bytes = '{BYTE_ZERO, BYTE_ZERO, BYTE_ONE, ID_PACK,
                      BYTE_ZERO, BYTE_ZERO, BYTE_ONE, ID_VIDEO,
                      BYTE_ZERO, 8'h04, 8'h80, 8'h80, BYTE_ZERO, 8'h77};
      send_chunk(SIZE_BITS'(chunk_bytes.size()), 1'b1, 1'b1);
   endtask

   task automatic test_single_pes_frame();
      chunk_bytes = '{BYTE_ZERO, BYTE_ZERO, BYTE_ONE, ID_VIDEO,
                      BYTE_ZERO, 8'h07, 8'h80, 8'hFF, BYTE_ZERO,
                      BYTE_ZERO, BYTE_ZERO, BYTE_ZERO, BYTE_ONE};
      send_chunk(SIZE_BITS'(chunk_bytes.size()), 1'b1, 1'b1);
   endtask

   task automatic test_random_streams(input int n_items, input int src_pct, input int rsp_pct);
      int                   stop_at;
      int                   pick;
      logic [SIZE_BITS-1:0] size;
      src_idle_pct = src_pct;
      rsp_idle_pct = rsp_pct;
      stop_at      = items_sent + n_items;
      while (items_sent < stop_at) begin
         pick = $urandom_range(0, 9);
         chunk_bytes.delete();
         if (pick < 4) begin
            add_pes();
            if ($urandom_range(0, 6) == 0)
               size = SIZE_BITS'($urandom_range(0, last_pes_len + 5));
            else
               size = SIZE_BITS'(last_pes_len + PES_OVERHEAD + $urandom_range(0, 3));
            if ($urandom_range(0, 3) == 0)
               repeat ($urandom_range(1, 4)) chunk_bytes.push_back(rnd_byte());
            send_chunk(size, $urandom_range(0, 7) != 0, 1'b1);
         end else if (pick < 8) begin
            chunk_bytes = '{BYTE_ZERO, BYTE_ZERO, BYTE_ONE, ID_PACK};
            repeat ($urandom_range(0, 6)) chunk_bytes.push_back(rnd_byte());
            repeat ($urandom_range(1, 3)) begin
               add_pes();
               repeat ($urandom_range(0, 3)) chunk_bytes.push_back(rnd_byte());
            end
            if ($urandom_range(0, 5) == 0) begin
               chunk_bytes.push_back(BYTE_ZERO);
               chunk_bytes.push_back(BYTE_ZERO);
               chunk_bytes.push_back(BYTE_ONE);
               chunk_bytes.push_back(ID_VIDEO);
            end
            case ($urandom_range(0, 9))
               0:       size = SIZE_BITS'($urandom_range(0, (1 << SIZE_BITS) - 1));
               1:       size = SIZE_BITS'(chunk_bytes.size() - 1);
               default: size = SIZE_BITS'(chunk_bytes.size());
            endcase
            send_chunk(size, $urandom_range(0, 7) != 0, 1'b1);
         end else if (pick == 8) begin
            chunk_bytes = '{BYTE_ZERO, BYTE_ZERO, BYTE_ONE, rnd_byte()};
            repeat ($urandom_range(0, 4)) chunk_bytes.push_back(rnd_byte());
            send_chunk(SIZE_BITS'($urandom_range(0, (1 << SIZE_BITS) - 1)),
                       $urandom_range(0, 1) == 1, 1'b0);
         end else begin
            repeat ($urandom_range(1, 8))
               send_req(rnd_byte(), $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0,
                        SIZE_BITS'($urandom_range(0, (1 << SIZE_BITS) - 1)));
         end
      end
   endtask

   always @(negedge clock)
      rsp_chan.ready <= (rsp_idle_pct == 0) || ($urandom_range(0, 99) >= rsp_idle_pct);

   always @(posedge clock) begin : check_es
      es_result_type want;
      if (!reset && rsp_chan.valid === 1'b1 && rsp_chan.ready === 1'b1) begin
         if (expected_es.size() == 0) begin
            $error("unexpected result: es_byte %h frame_start %b run_last %b",
                   rsp_chan.es_byte, rsp_chan.frame_start, rsp_chan.run_last);
            fail_count++;
         end else begin
            want = expected_es.pop_front();
            results_seen++;
            if (want.frame_start)
               frames_seen++;
            if (rsp_chan.es_byte !== want.es_byte) begin
               $error("es_byte: expected %h, actual %h", want.es_byte, rsp_chan.es_byte);
               fail_count++;
            end
            if (rsp_chan.frame_start !== want.frame_start) begin
               $error("frame_start: expected %b, actual %b",
                      want.frame_start, rsp_chan.frame_start);
               fail_count++;
            end
            if (rsp_chan.run_last !== want.run_last) begin
               $error("run_last: expected %b, actual %b", want.run_last, rsp_chan.run_last);
               fail_count++;
            end
         end
      end
   end

   initial begin
      #5_000_000;
      $display("CHECK FAILED");
      $finish;
   end

   initial begin : main
      int drain;
      reset                = 1'b1;
      req_chan.valid       = 1'b0;
      req_chan.data_byte   = '0;
      req_chan.chunk_first = 1'b0;
      req_chan.chunk_last  = 1'b0;
      req_chan.chunk_size  = '0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      test_pack_scan_drop();
      test_single_pes_frame();
      test_random_streams(115, 25, 56);
      test_random_streams(115, 56, 25);
      test_random_streams(110, 0, 0);

      req_chan.valid <= 1'b0;
      drain = 0;
      while (expected_es.size() != 0 && drain < 5000) begin
         @(posedge clock);
         drain++;
      end
      if (expected_es.size() != 0) begin
         $error("%0d expected ES bytes never arrived", expected_es.size());
         fail_count++;
      end
      repeat (8) @(posedge clock);

      $display("Sent %0d requests (%0d in PS chunks) under three stall mixes.",
               items_sent, stream_items);
      $display("Checked %0d ES bytes, %0d of them frame starts.", results_seen, frames_seen);
      if (fail_count == 0)
         $display("CHECK OK");
      else
         $display("CHECK FAILED");
      $finish;
   end

endmodule
